// ===== rtl/rda_pkg.sv =====
// ============================================================================
// RGBA density accumulate package
// Shared constants, operation codes and types for the density layering block.
// ============================================================================
package rda_pkg;

   localparam int MAX_WHOLE_DEF = 15;
   localparam int FRAC_BITS_DEF = 16;

   localparam int WHOLE_W = 4;
   localparam int DF_BITS = 16;

   localparam logic [DF_BITS:0]   DF_ONE  = 17'h10000;
   localparam logic [DF_BITS-1:0] DF_HALF = 16'h8000;

   localparam logic [WHOLE_W-1:0] WHOLE_RESET = 4'd1;
   localparam logic [DF_BITS-1:0] FRAC_RESET  = 16'd0;

   typedef logic [0:0] csr_index_type;
   localparam csr_index_type REG_DENSITY_WHOLE = 1'b0;
   localparam csr_index_type REG_DENSITY_FRAC  = 1'b1;

   typedef logic [3:0] op_type;
   localparam op_type OP_HOLD   = 4'd0;
   localparam op_type OP_LOAD   = 4'd1;
   localparam op_type OP_LAYER  = 4'd2;
   localparam op_type OP_NEXT   = 4'd3;
   localparam op_type OP_KEEP   = 4'd4;
   localparam op_type OP_MIX    = 4'd5;
   localparam op_type OP_SCALE  = 4'd6;
   localparam op_type OP_ZERO   = 4'd7;
   localparam op_type OP_CLAMP  = 4'd8;
   localparam op_type OP_BLEND1 = 4'd9;
   localparam op_type OP_BLEND2 = 4'd10;

endpackage

// ===== rtl/rda_lane.sv =====
// ============================================================================
// RGBA density accumulate channel lane
// One multiply-add unit and its working registers for one color channel.
// ============================================================================
module rda_lane
   import rda_pkg::*;
#(
   parameter int MAX_WHOLE = MAX_WHOLE_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  op_type               op,
   input  logic [FRAC_BITS:0]   src,
   input  logic [FRAC_BITS:0]   trans,
   input  logic [FRAC_BITS:0]   wgt,
   input  logic [DF_BITS-1:0]   frac,
   output logic [FRAC_BITS:0]   result
);

   localparam int CH_W  = FRAC_BITS + 1;
   localparam int ACC_W = CH_W + $clog2(MAX_WHOLE + 2);
   localparam int B_W   = (CH_W > DF_BITS + 1) ? CH_W : DF_BITS + 1;
   localparam int P_W   = ACC_W + B_W;
   localparam int S_W   = P_W + 1;

   localparam logic [CH_W-1:0]  ONE       = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [ACC_W-1:0] ONE_A     = ACC_W'(ONE);
   localparam logic [S_W-1:0]   ONE_S     = S_W'(ONE);
   localparam logic [S_W-1:0]   HALF_S    = S_W'(1) << (FRAC_BITS - 1);
   localparam logic [S_W-1:0]   DF_HALF_S = S_W'(DF_HALF);

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] nxt_ff, nxt_in;
   logic [S_W-1:0]   sum_ff, sum_in;
   logic [CH_W-1:0]  orig_ff, orig_in;

   logic [ACC_W-1:0] mul_a;
   logic [B_W-1:0]   mul_b;
   logic [P_W-1:0]   prod;
   logic [S_W-1:0]   rnd_q;
   logic [S_W-1:0]   mix_q;
   logic [S_W-1:0]   blend_q;
   logic [S_W-1:0]   scale_q;

   always_comb begin
      mul_a = acc_ff;
      mul_b = B_W'(trans);
      case (op)
         OP_KEEP: begin
            mul_b = B_W'(DF_ONE) - B_W'(frac);
         end
         OP_MIX: begin
            mul_a = nxt_ff;
            mul_b = B_W'(frac);
         end
         OP_SCALE: begin
            mul_a = ACC_W'(orig_ff);
            mul_b = B_W'(frac);
         end
         OP_BLEND1: begin
            mul_b = B_W'(wgt);
         end
         OP_BLEND2: begin
            mul_a = ACC_W'(orig_ff);
            mul_b = B_W'(ONE) - B_W'(wgt);
         end
         default: begin
            mul_a = acc_ff;
            mul_b = B_W'(trans);
         end
      endcase
   end

   assign prod    = P_W'(mul_a) * P_W'(mul_b);
   assign rnd_q   = (S_W'(prod) + HALF_S) >> FRAC_BITS;
   assign mix_q   = (sum_ff + S_W'(prod) + DF_HALF_S) >> DF_BITS;
   assign scale_q = (S_W'(prod) + DF_HALF_S) >> DF_BITS;
   assign blend_q = (sum_ff + S_W'(prod) + HALF_S) >> FRAC_BITS;

   always_comb begin
      acc_in  = acc_ff;
      nxt_in  = nxt_ff;
      sum_in  = sum_ff;
      orig_in = orig_ff;
      case (op)
         OP_LOAD: begin
            orig_in = src;
            acc_in  = ACC_W'(src);
         end
         OP_LAYER: begin
            acc_in = ACC_W'(rnd_q) + ACC_W'(orig_ff);
         end
         OP_NEXT: begin
            nxt_in = ACC_W'(rnd_q) + ACC_W'(orig_ff);
         end
         OP_KEEP: begin
            sum_in = S_W'(prod);
         end
         OP_MIX: begin
            acc_in = ACC_W'(mix_q);
         end
         OP_SCALE: begin
            acc_in = ACC_W'(scale_q);
         end
         OP_ZERO: begin
            acc_in = '0;
         end
         OP_CLAMP: begin
            acc_in = (acc_ff > ONE_A) ? ONE_A : acc_ff;
         end
         OP_BLEND1: begin
            sum_in = S_W'(prod);
         end
         OP_BLEND2: begin
            acc_in = (blend_q > ONE_S) ? ONE_A : ACC_W'(blend_q);
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      nxt_ff  <= nxt_in;
      sum_ff  <= sum_in;
      orig_ff <= orig_in;
   end

   assign result = acc_ff[CH_W-1:0];

endmodule

// ===== rtl/rda_seq.sv =====
// ============================================================================
// RGBA density accumulate sequencer
// Steps the channel lanes through the layering, fraction, clamp and blend.
// ============================================================================
module rda_seq
   import rda_pkg::*;
#(
   parameter int MAX_WHOLE = MAX_WHOLE_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WHOLE_W-1:0]   density_whole,
   input  logic [DF_BITS-1:0]   density_frac,
   input  logic [FRAC_BITS:0]   alpha,
   input  logic [FRAC_BITS:0]   weight,
   input  logic                 ref_present,
   input  logic                 last_pixel,
   output logic                 busy,
   output op_type               op,
   output logic [FRAC_BITS:0]   trans,
   output logic [FRAC_BITS:0]   wgt,
   output logic                 rsp_valid,
   output logic                 last_out
);

   localparam int CH_W  = FRAC_BITS + 1;
   localparam int CNT_W = $clog2(MAX_WHOLE + 1);
   localparam int W_W   = (CNT_W > WHOLE_W) ? CNT_W : WHOLE_W;

   localparam logic [CH_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_LOOP   = 4'd1;
   localparam logic [3:0] S_NEXT   = 4'd2;
   localparam logic [3:0] S_KEEP   = 4'd3;
   localparam logic [3:0] S_MIX    = 4'd4;
   localparam logic [3:0] S_SCALE  = 4'd5;
   localparam logic [3:0] S_ZERO   = 4'd6;
   localparam logic [3:0] S_CLAMP  = 4'd7;
   localparam logic [3:0] S_BLEND1 = 4'd8;
   localparam logic [3:0] S_BLEND2 = 4'd9;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CH_W-1:0]  trans_ff, trans_in;
   logic [CH_W-1:0]  wgt_ff, wgt_in;
   logic             ref_ff, ref_in;
   logic             last_ff, last_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [W_W-1:0]   whole_ext;
   logic [W_W-1:0]   whole_sat;
   logic [3:0]       after_loop;
   logic             take;

   assign take       = start && (state_ff == S_IDLE);
   assign whole_ext  = W_W'(density_whole);
   assign whole_sat  = (whole_ext > W_W'(MAX_WHOLE)) ? W_W'(MAX_WHOLE) : whole_ext;
   assign after_loop = (density_frac != '0) ? S_NEXT : S_CLAMP;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      trans_in     = trans_ff;
      wgt_in       = wgt_ff;
      ref_in       = ref_ff;
      last_in      = last_ff;
      rsp_valid_in = 1'b0;
      op           = OP_HOLD;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op       = OP_LOAD;
               trans_in = (alpha > ONE) ? '0 : ONE - alpha;
               wgt_in   = (weight > ONE) ? ONE : weight;
               ref_in   = ref_present;
               last_in  = last_pixel;
               cnt_in   = CNT_W'(whole_sat - W_W'(1));
               if (whole_sat == '0) begin
                  state_in = (density_frac != '0) ? S_SCALE : S_ZERO;
               end else if (whole_sat == W_W'(1)) begin
                  state_in = after_loop;
               end else begin
                  state_in = S_LOOP;
               end
            end
         end
         S_LOOP: begin
            op     = OP_LAYER;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = after_loop;
            end
         end
         S_NEXT: begin
            op       = OP_NEXT;
            state_in = S_KEEP;
         end
         S_KEEP: begin
            op       = OP_KEEP;
            state_in = S_MIX;
         end
         S_MIX: begin
            op       = OP_MIX;
            state_in = S_CLAMP;
         end
         S_SCALE: begin
            op       = OP_SCALE;
            state_in = S_CLAMP;
         end
         S_ZERO: begin
            op       = OP_ZERO;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            op = OP_CLAMP;
            if (ref_ff) begin
               state_in = S_BLEND1;
            end else begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         S_BLEND1: begin
            op       = OP_BLEND1;
            state_in = S_BLEND2;
         end
         S_BLEND2: begin
            op           = OP_BLEND2;
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff   <= cnt_in;
      trans_ff <= trans_in;
      wgt_ff   <= wgt_in;
      ref_ff   <= ref_in;
      last_ff  <= last_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign trans     = trans_ff;
   assign wgt       = wgt_ff;
   assign rsp_valid = rsp_valid_ff;
   assign last_out  = last_ff;

`ifndef NO_ASSERTIONS
   a_take_goes_busy: assert property (@(posedge clock) disable iff (reset)
      take |=> busy)
      else $error("Accepted word did not start the sequence.");
   a_loop_count_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOP) |-> (cnt_ff != '0))
      else $error("Layer loop entered with an exhausted count.");
`endif

endmodule

// ===== rtl/rgba_density_accumulate.sv =====
// ============================================================================
// RGBA density accumulate
// Layers each channel of an RGBA pixel over itself by a programmed density.
// ============================================================================
// A word is taken on req_* at a clock edge where start is high and busy is
// low. busy then stays high while the four channel lanes, each with its own
// multiplier, work through the word under one sequencer. The result appears
// on rsp_* for exactly one cycle with rsp_valid high; the receiver cannot
// hold it off, and busy is already low in that cycle, so the next word can be
// taken at the same edge that takes the result.
// After the accepting edge the sequencer runs (whole - 1) layer steps,
// then three fraction steps for a nonzero fraction (or one scale or zero
// step when whole is zero), then one clamp step, then two blend steps when
// ref_present is set; whole is density_whole limited to MAX_WHOLE.
// The layer loop is the long part: each step needs the previous product.
// csr_* writes density_whole (index 0) and density_frac (index 1); write them
// only while no word is in flight. Reset returns to idle with density 1.0.
// ============================================================================
module rgba_density_accumulate
   import rda_pkg::*;
#(
   parameter int MAX_WHOLE = MAX_WHOLE_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [FRAC_BITS:0]   req_red_in,
   input  logic [FRAC_BITS:0]   req_green_in,
   input  logic [FRAC_BITS:0]   req_blue_in,
   input  logic [FRAC_BITS:0]   req_alpha_in,
   input  logic [FRAC_BITS:0]   req_ref_weight,
   input  logic                 req_ref_present,
   input  logic                 req_last_pixel,
   output logic                 rsp_valid,
   output logic [FRAC_BITS:0]   rsp_red_out,
   output logic [FRAC_BITS:0]   rsp_green_out,
   output logic [FRAC_BITS:0]   rsp_blue_out,
   output logic [FRAC_BITS:0]   rsp_alpha_out,
   output logic                 rsp_last_pixel_out,
   input  logic                 csr_write_en,
   input  csr_index_type        csr_index,
   input  logic [DF_BITS-1:0]   csr_wdata
);

   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic [WHOLE_W-1:0]  density_whole_ff, density_whole_in;
   logic [DF_BITS-1:0]  density_frac_ff, density_frac_in;

   op_type              op;
   logic [FRAC_BITS:0]  trans;
   logic [FRAC_BITS:0]  wgt;

   always_comb begin
      density_whole_in = density_whole_ff;
      density_frac_in  = density_frac_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_DENSITY_WHOLE: density_whole_in = csr_wdata[WHOLE_W-1:0];
            REG_DENSITY_FRAC:  density_frac_in  = csr_wdata;
            default: begin
               density_whole_in = density_whole_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         density_whole_ff <= WHOLE_RESET;
         density_frac_ff  <= FRAC_RESET;
      end else begin
         density_whole_ff <= density_whole_in;
         density_frac_ff  <= density_frac_in;
      end
   end

   rda_seq #(
      .MAX_WHOLE (MAX_WHOLE),
      .FRAC_BITS (FRAC_BITS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .density_whole (density_whole_ff),
      .density_frac  (density_frac_ff),
      .alpha         (req_alpha_in),
      .weight        (req_ref_weight),
      .ref_present   (req_ref_present),
      .last_pixel    (req_last_pixel),
      .busy          (busy),
      .op            (op),
      .trans         (trans),
      .wgt           (wgt),
      .rsp_valid     (rsp_valid),
      .last_out      (rsp_last_pixel_out)
   );

   rda_lane #(
      .MAX_WHOLE (MAX_WHOLE),
      .FRAC_BITS (FRAC_BITS)
   ) u_lane_red (
      .clock  (clock),
      .op     (op),
      .src    (req_red_in),
      .trans  (trans),
      .wgt    (wgt),
      .frac   (density_frac_ff),
      .result (rsp_red_out)
   );

   rda_lane #(
      .MAX_WHOLE (MAX_WHOLE),
      .FRAC_BITS (FRAC_BITS)
   ) u_lane_green (
      .clock  (clock),
      .op     (op),
      .src    (req_green_in),
      .trans  (trans),
      .wgt    (wgt),
      .frac   (density_frac_ff),
      .result (rsp_green_out)
   );

   rda_lane #(
      .MAX_WHOLE (MAX_WHOLE),
      .FRAC_BITS (FRAC_BITS)
   ) u_lane_blue (
      .clock  (clock),
      .op     (op),
      .src    (req_blue_in),
      .trans  (trans),
      .wgt    (wgt),
      .frac   (density_frac_ff),
      .result (rsp_blue_out)
   );

   rda_lane #(
      .MAX_WHOLE (MAX_WHOLE),
      .FRAC_BITS (FRAC_BITS)
   ) u_lane_alpha (
      .clock  (clock),
      .op     (op),
      .src    (req_alpha_in),
      .trans  (trans),
      .wgt    (wgt),
      .frac   (density_frac_ff),
      .result (rsp_alpha_out)
   );

`ifndef NO_ASSERTIONS
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("Result word shown while the block is still busy.");
   a_busy_ends_in_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("Sequence ended without a result word.");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Result strobe held for more than one cycle.");
   a_rsp_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red_out <= ONE) && (rsp_green_out <= ONE) &&
                    (rsp_blue_out <= ONE) && (rsp_alpha_out <= ONE))
      else $error("Result channel above one.");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// ============================================================================
// RGBA density accumulate testbench
// Sends RGBA pixel words through the density layering block under a range of
// density settings and sender idle rates. Each word accepted by the block is
// predicted in the bench and checked against the layered pixel that returns.
// ============================================================================
module tb
   import rda_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 10;
   localparam int WORDS_PER_PHASE = 165;
   localparam int MAX_PRINTED    = 30;

   typedef struct packed {
      logic [16:0] red;
      logic [16:0] green;
      logic [16:0] blue;
      logic [16:0] alpha;
      logic [16:0] weight;
      logic        blend;
      logic        last;
   } pixel_word_type;

   typedef struct packed {
      logic [16:0] red;
      logic [16:0] green;
      logic [16:0] blue;
      logic [16:0] alpha;
      logic        last;
   } layered_pixel_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [16:0]         req_red_in = '0;
   logic [16:0]         req_green_in = '0;
   logic [16:0]         req_blue_in = '0;
   logic [16:0]         req_alpha_in = '0;
   logic [16:0]         req_ref_weight = '0;
   logic                req_ref_present = 1'b0;
   logic                req_last_pixel = 1'b0;
   logic                rsp_valid;
   logic [16:0]         rsp_red_out;
   logic [16:0]         rsp_green_out;
   logic [16:0]         rsp_blue_out;
   logic [16:0]         rsp_alpha_out;
   logic                rsp_last_pixel_out;
   logic                csr_write_en = 1'b0;
   csr_index_type       csr_index = REG_DENSITY_WHOLE;
   logic [DF_BITS-1:0]  csr_wdata = '0;

   pixel_word_type      pixel_queue[$];
   layered_pixel_type   layered_pixels_due[$];
   pixel_word_type      word_on_port = '0;
   logic [WHOLE_W-1:0]  density_layers = WHOLE_RESET;
   logic [DF_BITS-1:0]  density_fraction = FRAC_RESET;
   int                  sender_idle_pct = 0;
   int                  error_count = 0;
   int                  words_sent = 0;
   int                  pixels_checked = 0;
   int                  settings_run = 1;
   int                  quiet_cycles = 0;

   rgba_density_accumulate DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_red_in         (req_red_in),
      .req_green_in       (req_green_in),
      .req_blue_in        (req_blue_in),
      .req_alpha_in       (req_alpha_in),
      .req_ref_weight     (req_ref_weight),
      .req_ref_present    (req_ref_present),
      .req_last_pixel     (req_last_pixel),
      .rsp_valid          (rsp_valid),
      .rsp_red_out        (rsp_red_out),
      .rsp_green_out      (rsp_green_out),
      .rsp_blue_out       (rsp_blue_out),
      .rsp_alpha_out      (rsp_alpha_out),
      .rsp_last_pixel_out (rsp_last_pixel_out),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic layered_pixel_type predict_layered_pixel(pixel_word_type w);
      bit [47:0]         one_q;
      bit [47:0]         half_q;
      bit [47:0]         trans;
      bit [47:0]         wt;
      bit [47:0]         orig;
      bit [47:0]         acc;
      bit [47:0]         one_more;
      bit [47:0]         frac;
      bit [16:0]         chan[4];
      bit [16:0]         outs[4];
      int                whole;
      layered_pixel_type r;
      one_q  = 48'd65536;
      half_q = 48'd32768;
      trans  = (w.alpha > one_q) ? 48'd0 : one_q - w.alpha;
      wt     = (w.weight > one_q) ? one_q : 48'(w.weight);
      whole  = density_layers;
      frac   = density_fraction;
      if (whole > MAX_WHOLE_DEF)
         whole = MAX_WHOLE_DEF;
      chan = '{w.red, w.green, w.blue, w.alpha};
      for (int k = 0; k < 4; k++) begin
         orig = chan[k];
         acc  = orig;
         if (whole >= 1) begin
            for (int i = 1; i < whole; i++)
               acc = ((acc * trans + half_q) >> 16) + orig;
            if (frac != 0) begin
               one_more = ((acc * trans + half_q) >> 16) + orig;
               acc = (acc * (48'd65536 - frac) + one_more * frac + 48'd32768) >> 16;
            end
         end else if (frac != 0) begin
            acc = (orig * frac + 48'd32768) >> 16;
         end else begin
            acc = 0;
         end
         if (acc > one_q)
            acc = one_q;
         if (w.blend) begin
            acc = (acc * wt + orig * (one_q - wt) + half_q) >> 16;
            if (acc > one_q)
               acc = one_q;
         end
         outs[k] = acc[16:0];
      end
      r.red   = outs[0];
      r.green = outs[1];
      r.blue  = outs[2];
      r.alpha = outs[3];
      r.last  = w.last;
      return r;
   endfunction

   function automatic pixel_word_type make_word(int r, int g, int b, int a, int wt,
                                                bit blend, bit last);
      pixel_word_type w;
      w.red    = 17'(r);
      w.green  = 17'(g);
      w.blue   = 17'(b);
      w.alpha  = 17'(a);
      w.weight = 17'(wt);
      w.blend  = blend;
      w.last   = last;
      return w;
   endfunction

   function automatic logic [16:0] random_channel();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return 17'd0;
               1: return 17'd1;
               2: return 17'd65535;
               3: return 17'd65536;
               default: return 17'd131071;
            endcase
         end
         1: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("ERROR at %0t ns: %s", $time, msg);
   endtask

   task automatic write_density(input logic [WHOLE_W-1:0] whole,
                                input logic [DF_BITS-1:0] frac);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= REG_DENSITY_WHOLE;
      csr_wdata    <= {12'($urandom), whole};
      @(posedge clock);
      csr_index    <= REG_DENSITY_FRAC;
      csr_wdata    <= frac;
      @(posedge clock);
      csr_write_en <= 1'b0;
      density_layers   = whole;
      density_fraction = frac;
      settings_run++;
      @(negedge clock);
   endtask

   task automatic wait_until_idle();
      @(negedge clock);
      while (pixel_queue.size() != 0 || start || layered_pixels_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic queue_directed_words();
      pixel_queue.push_back(make_word(0, 0, 0, 0, 0, 0, 0));
      pixel_queue.push_back(make_word(65536, 65536, 65536, 65536, 65536, 1, 0));
      pixel_queue.push_back(make_word(131071, 131071, 131071, 0, 131071, 1, 1));
      pixel_queue.push_back(make_word(30000, 40000, 50000, 100000, 0, 0, 0));
      pixel_queue.push_back(make_word(70000, 12345, 65535, 32768, 0, 0, 0));
      pixel_queue.push_back(make_word(40000, 20000, 10000, 16384, 90000, 1, 0));
      pixel_queue.push_back(make_word(40000, 20000, 10000, 16384, 0, 1, 0));
      pixel_queue.push_back(make_word(65535, 1, 32768, 1, 32768, 1, 1));
      pixel_queue.push_back(make_word(0, 65536, 1, 65535, 1, 1, 0));
      pixel_queue.push_back(make_word(100000, 131071, 65537, 131071, 65537, 1, 0));
      pixel_queue.push_back(make_word(43690, 21845, 87381, 43690, 43690, 0, 1));
      pixel_queue.push_back(make_word(1, 2, 3, 65536, 65535, 1, 0));
   endtask

   always @(posedge clock) begin : drive_words
      pixel_word_type nxt;
      logic           go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         go = start && busy;
         if (start && !busy) begin
            layered_pixels_due.push_back(predict_layered_pixel(word_on_port));
            words_sent++;
         end
         if (!(start && busy)) begin
            if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               nxt = pixel_queue.pop_front();
               word_on_port    = nxt;
               req_red_in      <= nxt.red;
               req_green_in    <= nxt.green;
               req_blue_in     <= nxt.blue;
               req_alpha_in    <= nxt.alpha;
               req_ref_weight  <= nxt.weight;
               req_ref_present <= nxt.blend;
               req_last_pixel  <= nxt.last;
               go = 1'b1;
            end else begin
               go = 1'b0;
            end
         end
         start <= go;
      end
   end

   always @(posedge clock) begin : check_results
      layered_pixel_type want;
      if (!reset && rsp_valid) begin
         if (layered_pixels_due.size() == 0) begin
            report_mismatch("result word arrived with no pixel outstanding");
         end else begin
            want = layered_pixels_due.pop_front();
            pixels_checked++;
            if (rsp_red_out !== want.red)
               report_mismatch($sformatf("red got %0d expected %0d", rsp_red_out, want.red));
            if (rsp_green_out !== want.green)
               report_mismatch($sformatf("green got %0d expected %0d",
                                         rsp_green_out, want.green));
            if (rsp_blue_out !== want.blue)
               report_mismatch($sformatf("blue got %0d expected %0d",
                                         rsp_blue_out, want.blue));
            if (rsp_alpha_out !== want.alpha)
               report_mismatch($sformatf("alpha got %0d expected %0d",
                                         rsp_alpha_out, want.alpha));
            if (rsp_last_pixel_out !== want.last)
               report_mismatch($sformatf("last_pixel got %0b expected %0b",
                                         rsp_last_pixel_out, want.last));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without a word moving", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin : run_phases
      logic [WHOLE_W-1:0] whole_set[RANDOM_PHASES];
      logic [DF_BITS-1:0] frac_set[RANDOM_PHASES];
      int                 idle_set[4];
      pixel_word_type     w;
      whole_set = '{4'd0, 4'd0, 4'd15, 4'd15, 4'd1, 4'd2, 4'd4, 4'd8,
                    4'($urandom), 4'($urandom)};
      frac_set  = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 16'h8000,
                    16'($urandom), 16'hFFFF, 16'($urandom), 16'($urandom)};
      idle_set  = '{0, 74, 22, 74};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      queue_directed_words();
      wait_until_idle();
      write_density(4'd15, 16'hFFFF);
      queue_directed_words();
      wait_until_idle();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_density(whole_set[p], frac_set[p]);
         sender_idle_pct = idle_set[p % 4];
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            w.red    = random_channel();
            w.green  = random_channel();
            w.blue   = random_channel();
            w.alpha  = random_channel();
            w.weight = random_channel();
            w.blend  = 1'($urandom_range(0, 1));
            w.last   = ($urandom_range(0, 15) == 0);
            pixel_queue.push_back(w);
         end
         wait_until_idle();
      end
      repeat (40) @(posedge clock);
      if (layered_pixels_due.size() != 0)
         report_mismatch($sformatf("%0d pixels never returned", layered_pixels_due.size()));
      $display("Sent %0d pixel words under %0d density settings, checked %0d results.",
               words_sent, settings_run, pixels_checked);
      $display("Sender idle rates of 0, 22 and 74 percent; %0d mismatches.", error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== rgba_density_accumulate.f =====
rtl/rda_pkg.sv
rtl/rda_lane.sv
rtl/rda_seq.sv
rtl/rgba_density_accumulate.sv
tb/sv/tb.sv
